### rtl/core/assert_macros.svh
// Assertion macros shared by the prefetch detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is low.
`define SPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/spd_pkg.sv
// Shared constants, codes and types of the stream prefetch detector.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

    localparam int STREAM_COUNT = 8;
    localparam int LOOKAHEAD    = 4;
    localparam int LINE_BYTES   = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int ADDR_W       = 48;
    localparam int LIMIT_W      = 49;
    localparam int PDATA_W      = 64;
    localparam int PADDR_W      = 4;

    localparam int IDX_W      = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
    localparam int AGE_W      = IDX_W;
    localparam int LINE_SHIFT = $clog2(LINE_BYTES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int SPAN       = LOOKAHEAD * LINE_BYTES;
    localparam int K_W        = $clog2(LOOKAHEAD + 2);
    localparam int BOUND_W    = ADDR_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W-1:0]  LINE_A   = ADDR_W'(LINE_BYTES);
    localparam logic [ADDR_W:0]    LINE_EXT = (ADDR_W + 1)'(LINE_BYTES);
    localparam logic [BOUND_W-1:0] LINE_B   = BOUND_W'(LINE_BYTES);
    localparam logic [BOUND_W-1:0] SPAN_B   = BOUND_W'(SPAN);
    localparam logic [K_W-1:0]     K_LAST   = K_W'(LOOKAHEAD + 1);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(STREAM_COUNT - 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64'h1_0000_0000);

    // Register index, taken from paddr[3]
    localparam logic REG_MEMORY_LIMIT = 1'b0;

    // Stream confidence codes; the unused code reads as invalid
    localparam logic [1:0] CONF_INVALID  = 2'd0;
    localparam logic [1:0] CONF_TRAINING = 2'd1;
    localparam logic [1:0] CONF_STEADY   = 2'd2;

    // Stream direction codes
    localparam logic [1:0] DIR_UNKNOWN  = 2'd0;
    localparam logic [1:0] DIR_FORWARD  = 2'd1;
    localparam logic [1:0] DIR_BACKWARD = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SCAN,
        FS_WAIT
    } t_front_state;

    typedef enum logic {
        BS_IDLE,
        BS_RUN
    } t_back_state;

    // Burst request from the front to the back
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_addr            miss;
        t_addr            head;
        logic             fwd;
    } t_cmd;

    // End-of-burst update from the back to the stream table
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        t_addr            head;
        logic             demote;
    } t_wb;

endpackage

`default_nettype wire

### rtl/core/spd_front.sv
// Stream table, sequential match search, training and LRU replacement.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spd_pkg::t_addr i_miss_address,
    input  logic           i_miss_valid,
    output logic           o_miss_ready,
    output spd_pkg::t_cmd  o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    input  spd_pkg::t_wb   i_wb
);

    spd_pkg::t_front_state r_state, n_state;

    logic [1:0]                 r_conf [spd_pkg::STREAM_COUNT];
    logic [1:0]                 r_dir  [spd_pkg::STREAM_COUNT];
    spd_pkg::t_addr             r_last [spd_pkg::STREAM_COUNT];
    spd_pkg::t_addr             r_head [spd_pkg::STREAM_COUNT];
    logic [spd_pkg::AGE_W-1:0]  r_age  [spd_pkg::STREAM_COUNT];

    spd_pkg::t_addr             r_miss;
    logic [spd_pkg::ADDR_W:0]   r_miss_p;
    logic [spd_pkg::IDX_W-1:0]  r_scan, n_scan;
    logic [spd_pkg::IDX_W-1:0]  r_best, n_best;
    logic [spd_pkg::AGE_W-1:0]  r_best_age, n_best_age;

    logic [1:0]                 ent_conf;
    logic [1:0]                 ent_dir;
    spd_pkg::t_addr             ent_last;
    spd_pkg::t_addr             ent_head;
    logic [spd_pkg::AGE_W-1:0]  ent_age;
    logic [spd_pkg::ADDR_W:0]   last_p;
    logic [spd_pkg::ADDR_W:0    ] head_p;
    logic [spd_pkg::ADDR_W:0]   miss_x;
    logic                       tr_fwd, tr_bwd, st_fwd, st_bwd, hit, training;
    logic [spd_pkg::IDX_W-1:0]  cand_idx;
    logic [spd_pkg::AGE_W-1:0]  cand_age;

    logic                       accept, hit_go, alloc_go, do_touch;
    logic [spd_pkg::IDX_W-1:0]  touch_idx;
    logic [spd_pkg::AGE_W-1:0]  touch_age;

    // Match logic for the entry under the scan pointer
    always_comb begin
        ent_conf = r_conf[r_scan];
        ent_dir  = r_dir[r_scan];
        ent_last = r_last[r_scan];
        ent_head = r_head[r_scan];
        ent_age  = r_age[r_scan];
        last_p   = {1'b0, ent_last} + spd_pkg::LINE_EXT;
        head_p   = {1'b0, ent_head} + spd_pkg::LINE_EXT;
        miss_x   = {1'b0, r_miss};
        training = (ent_conf == spd_pkg::CONF_TRAINING);
        tr_fwd   = training && (last_p == miss_x);
        tr_bwd   = training && (r_miss_p == {1'b0, ent_last});
        st_fwd   = (ent_conf == spd_pkg::CONF_STEADY) && (ent_dir == spd_pkg::DIR_FORWARD)
                   && (miss_x >= last_p) && (miss_x <= head_p);
        st_bwd   = (ent_conf == spd_pkg::CONF_STEADY) && (ent_dir == spd_pkg::DIR_BACKWARD)
                   && ({1'b0, ent_last} >= r_miss_p) && (r_miss_p >= {1'b0, ent_head});
        hit      = tr_fwd || tr_bwd || st_fwd || st_bwd;

        // Running LRU victim: strictly older wins, so ties keep the lower index
        if ((r_scan == '0) || (ent_age > r_best_age)) begin
            cand_idx = r_scan;
            cand_age = ent_age;
        end else begin
            cand_idx = r_best;
            cand_age = r_best_age;
        end

        o_cmd.idx  = r_scan;
        o_cmd.miss = r_miss;
        o_cmd.head = training ? r_miss : ent_head;
        o_cmd.fwd  = tr_fwd || st_fwd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spd_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_best      = r_best;
        n_best_age  = r_best_age;
        o_miss_ready = 1'b0;
        o_cmd_valid = 1'b0;
        accept      = 1'b0;
        hit_go      = 1'b0;
        alloc_go    = 1'b0;
        do_touch    = 1'b0;
        touch_idx   = cand_idx;
        touch_age   = cand_age;
        unique case (r_state)
            spd_pkg::FS_IDLE: begin
                o_miss_ready = 1'b1;
                if (i_miss_valid) begin
                    accept  = 1'b1;
                    n_scan  = '0;
                    n_state = spd_pkg::FS_SCAN;
                end
            end
            spd_pkg::FS_SCAN: begin
                n_best     = cand_idx;
                n_best_age = cand_age;
                if (hit) begin
                    o_cmd_valid = 1'b1;
                    touch_idx   = r_scan;
                    touch_age   = ent_age;
                    if (i_cmd_ready) begin
                        hit_go   = 1'b1;
                        do_touch = 1'b1;
                        n_state  = spd_pkg::FS_WAIT;
                    end
                end else if (r_scan == spd_pkg::IDX_LAST) begin
                    alloc_go = 1'b1;
                    do_touch = 1'b1;
                    n_state  = spd_pkg::FS_IDLE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            spd_pkg::FS_WAIT: begin
                if (i_wb.valid) begin
                    n_state = spd_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = spd_pkg::FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_best     <= n_best;
        r_best_age <= n_best_age;
        if (accept) begin
            r_miss   <= i_miss_address;
            r_miss_p <= {1'b0, i_miss_address} + spd_pkg::LINE_EXT;
        end
    end

    // Control part of the table: confidence, direction and ages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < spd_pkg::STREAM_COUNT; j++) begin
                r_conf[j] <= spd_pkg::CONF_INVALID;
                r_dir[j]  <= spd_pkg::DIR_UNKNOWN;
                r_age[j]  <= spd_pkg::AGE_W'(spd_pkg::STREAM_COUNT - 1 - j);
            end
        end else begin
            if (do_touch) begin
                for (int j = 0; j < spd_pkg::STREAM_COUNT; j++) begin
                    if (spd_pkg::IDX_W'(j) == touch_idx) begin
                        r_age[j] <= '0;
                    end else if (r_age[j] < touch_age) begin
                        r_age[j] <= r_age[j] + 1'b1;
                    end
                end
            end
            if (hit_go && training) begin
                r_conf[r_scan] <= spd_pkg::CONF_STEADY;
                r_dir[r_scan]  <= tr_fwd ? spd_pkg::DIR_FORWARD : spd_pkg::DIR_BACKWARD;
            end
            if (alloc_go) begin
                r_conf[cand_idx] <= spd_pkg::CONF_TRAINING;
                r_dir[cand_idx]  <= spd_pkg::DIR_UNKNOWN;
            end
            if (i_wb.valid && i_wb.demote) begin
                r_conf[i_wb.idx] <= spd_pkg::CONF_TRAINING;
                r_dir[i_wb.idx]  <= spd_pkg::DIR_UNKNOWN;
            end
        end
    end

    // Line addresses are only read once their entry has been allocated
    always_ff @(posedge i_clk) begin
        if (hit_go) begin
            r_last[r_scan] <= r_miss;
            if (training) begin
                r_head[r_scan] <= r_miss;
            end
        end
        if (alloc_go) begin
            r_last[cand_idx] <= r_miss;
            r_head[cand_idx] <= r_miss;
        end
        if (i_wb.valid) begin
            r_head[i_wb.idx] <= i_wb.head;
        end
    end

    `SPD_ASSERT(a_wb_only_when_waiting, i_clk, i_rst_n, i_wb.valid |-> (r_state == spd_pkg::FS_WAIT), "burst update outside wait state")

endmodule

`default_nettype wire

### rtl/core/spd_cmd_queue.sv
// Two-entry request queue between the stream table and the burst engine.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spd_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  spd_pkg::t_cmd i_push_data,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    output spd_pkg::t_cmd o_pop_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready
);

    spd_pkg::t_cmd              r_mem [spd_pkg::QUEUE_DEPTH];
    logic [spd_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [spd_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [spd_pkg::QCNT_W-1:0] r_count;
    logic                       push_go, pop_go;

    assign o_push_ready = (r_count != spd_pkg::QCNT_W'(spd_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push_go      = i_push_valid && o_push_ready;
    assign pop_go       = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_go) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_go) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_go && !pop_go) begin
                r_count <= r_count + 1'b1;
            end else if (pop_go && !push_go) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_go) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `SPD_ASSERT(a_count_in_range, i_clk, i_rst_n, r_count <= spd_pkg::QCNT_W'(spd_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

### rtl/core/spd_back.sv
// Burst engine: steps the prefetch head one line a cycle while the prefetch output is not stalled, and drives results.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spd_pkg::t_cmd                 i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  logic [spd_pkg::LIMIT_W-1:0]   i_memory_limit,
    output spd_pkg::t_wb                  o_wb,
    output spd_pkg::t_addr                o_prefetch_address,
    output logic                          o_burst_last,
    output logic                          o_prefetch_valid,
    input  logic                          i_prefetch_ready
);

    spd_pkg::t_back_state r_state, n_state;

    spd_pkg::t_addr                     r_head;
    logic signed [spd_pkg::BOUND_W-1:0] r_bound;
    logic signed [spd_pkg::BOUND_W-1:0] r_lim_line;
    logic                               r_fwd;
    logic [spd_pkg::IDX_W-1:0]          r_idx;
    logic [spd_pkg::K_W-1:0]            r_k;
    logic                               r_pend_valid;
    spd_pkg::t_addr                     r_pend_addr;
    logic                               r_out_valid;
    spd_pkg::t_addr                     r_out_addr;
    logic                               r_out_last;

    logic signed [spd_pkg::BOUND_W-1:0] head_s;
    logic signed [spd_pkg::BOUND_W-1:0] miss_s;
    logic [spd_pkg::ADDR_W:0]           next_ext;
    logic                               out_free;
    logic                               span_break, page_edge, too_low, too_high;
    logic                               blocked, burst_full, stop;
    logic                               load, step, move_pend;

    always_comb begin
        head_s     = $signed({2'b00, r_head});
        miss_s     = $signed({2'b00, i_cmd.miss});
        next_ext   = r_fwd ? ({1'b0, r_head} + spd_pkg::LINE_EXT)
                           : {1'b0, r_head - spd_pkg::LINE_A};
        out_free   = !r_out_valid || i_prefetch_ready;
        burst_full = (r_k == spd_pkg::K_LAST);
        span_break = r_fwd ? (head_s >= r_bound) : (head_s <= r_bound);
        // Head on the last (or first) line of its page: the next line leaves it
        page_edge  = r_fwd ? (&r_head[spd_pkg::PAGE_SHIFT-1:spd_pkg::LINE_SHIFT])
                           : (~|r_head[spd_pkg::PAGE_SHIFT-1:spd_pkg::LINE_SHIFT]);
        too_low    = !r_fwd && (~|r_head[spd_pkg::ADDR_W-1:spd_pkg::LINE_SHIFT+1]);
        too_high   = ($signed({1'b0, next_ext}) > r_lim_line);
        blocked    = page_edge || too_low || too_high;
        stop       = burst_full || span_break || blocked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spd_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        load        = 1'b0;
        step        = 1'b0;
        move_pend   = 1'b0;
        o_wb.valid  = 1'b0;
        o_wb.idx    = r_idx;
        o_wb.head   = r_head;
        o_wb.demote = !burst_full && !span_break && blocked;
        unique case (r_state)
            spd_pkg::BS_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    load    = 1'b1;
                    n_state = spd_pkg::BS_RUN;
                end
            end
            spd_pkg::BS_RUN: begin
                if (out_free) begin
                    move_pend = r_pend_valid;
                    if (stop) begin
                        o_wb.valid = 1'b1;
                        n_state    = spd_pkg::BS_IDLE;
                    end else begin
                        step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = spd_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load || o_wb.valid) begin
                r_pend_valid <= 1'b0;
            end else if (step) begin
                r_pend_valid <= 1'b1;
            end
            if (move_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_prefetch_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // The user must change the limit only while idle (not enforced by the block); a registered copy is then safe
        r_lim_line <= $signed({1'b0, i_memory_limit}) - $signed(spd_pkg::LINE_B);
        if (load) begin
            r_head  <= i_cmd.head;
            r_fwd   <= i_cmd.fwd;
            r_idx   <= i_cmd.idx;
            r_k     <= '0;
            r_bound <= i_cmd.fwd ? (miss_s + $signed(spd_pkg::SPAN_B))
                                 : (miss_s - $signed(spd_pkg::SPAN_B));
        end else if (step) begin
            r_head      <= next_ext[spd_pkg::ADDR_W-1:0];
            r_pend_addr <= next_ext[spd_pkg::ADDR_W-1:0];
            r_k         <= r_k + 1'b1;
        end
        if (move_pend) begin
            r_out_addr <= r_pend_addr;
            r_out_last <= stop;
        end
    end

    assign o_prefetch_address = r_out_addr;
    assign o_burst_last       = r_out_last;
    assign o_prefetch_valid   = r_out_valid;

    `SPD_ASSERT(a_k_bounded, i_clk, i_rst_n, r_k <= spd_pkg::K_LAST || r_state == spd_pkg::BS_IDLE, "burst step count overrun")
    `SPD_ASSERT(a_wb_clears_pend, i_clk, i_rst_n, o_wb.valid |=> !r_pend_valid, "pending prefetch left after burst end")
    `SPD_ASSERT_ALWAYS(a_no_out_in_reset, i_clk, !i_rst_n |=> !r_out_valid, "result valid straight after reset")

endmodule

`default_nettype wire

### rtl/core/stream_prefetch_detector.sv
// Top level of the unit-stride stream prefetch detector.
//
//  port group         dir  handshake                    carries
//  miss request       in   i_miss_valid/o_miss_ready     i_miss_address
//  prefetch request   out  o_prefetch_valid/i_..._ready  o_prefetch_address, o_burst_last
//  register port      in   psel/penable/pwrite, pready   memory_limit at paddr 0
//
//  A miss request that hits goes through an accept step, a search of S (1..8) table
//  entries one a cycle, a burst load, B (0..5) prefetch steps and a close.
//  A miss request that matches no stream is accepted, then all eight entries are searched.
//  After a hit, the next miss is taken once the burst engine has written its head back to the table.
//  Synchronous reset marks all stream table entries invalid and presets the ages; no clearing pass.
//  A stalled prefetch output holds the burst engine; the table waits for it in turn.
`timescale 1ns / 1ps
`default_nettype none

module stream_prefetch_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [spd_pkg::ADDR_W-1:0]    i_miss_address,
    input  logic                          i_miss_valid,
    output logic                          o_miss_ready,
    output logic [spd_pkg::ADDR_W-1:0]    o_prefetch_address,
    output logic                          o_burst_last,
    output logic                          o_prefetch_valid,
    input  logic                          i_prefetch_ready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spd_pkg::PADDR_W-1:0]   paddr,
    input  logic [spd_pkg::PDATA_W-1:0]   pwdata,
    output logic [spd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [spd_pkg::LIMIT_W-1:0] r_memory_limit;
    logic                        reg_hit;

    spd_pkg::t_cmd front_cmd;
    logic          front_cmd_valid;
    logic          queue_push_ready;
    spd_pkg::t_cmd queue_cmd;
    logic          queue_cmd_valid;
    logic          back_cmd_ready;
    spd_pkg::t_wb  back_wb;

    // Registers sit on 8-byte slots; only the slot bit selects
    assign reg_hit = (paddr[spd_pkg::PADDR_W-1] == spd_pkg::REG_MEMORY_LIMIT);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(spd_pkg::PDATA_W - spd_pkg::LIMIT_W){1'b0}}, r_memory_limit}
                             : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_memory_limit <= spd_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_memory_limit <= pwdata[spd_pkg::LIMIT_W-1:0];
        end
    end

    spd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_miss_address (i_miss_address),
        .i_miss_valid   (i_miss_valid),
        .o_miss_ready   (o_miss_ready),
        .o_cmd          (front_cmd),
        .o_cmd_valid    (front_cmd_valid),
        .i_cmd_ready    (queue_push_ready),
        .i_wb           (back_wb)
    );

    spd_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_data  (front_cmd),
        .i_push_valid (front_cmd_valid),
        .o_push_ready (queue_push_ready),
        .o_pop_data   (queue_cmd),
        .o_pop_valid  (queue_cmd_valid),
        .i_pop_ready  (back_cmd_ready)
    );

    spd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (queue_cmd),
        .i_cmd_valid        (queue_cmd_valid),
        .o_cmd_ready        (back_cmd_ready),
        .i_memory_limit     (r_memory_limit),
        .o_wb               (back_wb),
        .o_prefetch_address (o_prefetch_address),
        .o_burst_last       (o_burst_last),
        .o_prefetch_valid   (o_prefetch_valid),
        .i_prefetch_ready   (i_prefetch_ready)
    );

endmodule

`default_nettype wire

### tb/sv/stream_prefetch_checker.sv
// Stream table predictor and prefetch request checker for the stream prefetch detector.
`timescale 1ns / 1ps

module stream_prefetch_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          miss_valid,
    input  logic                          miss_ready,
    input  logic [spd_pkg::ADDR_W-1:0]    miss_address,
    input  logic                          prefetch_valid,
    input  logic                          prefetch_ready,
    input  logic [spd_pkg::ADDR_W-1:0]    prefetch_address,
    input  logic                          burst_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [spd_pkg::PADDR_W-1:0]   paddr,
    input  logic [spd_pkg::PDATA_W-1:0]   pwdata,
    output int                            fail_count,
    output int                            pending_count,
    output int                            miss_count,
    output int                            prefetch_count,
    output int                            blocked_count
);

    typedef struct packed {
        spd_pkg::t_addr addr;
        logic           last;
    } t_prefetch;

    localparam logic [63:0] LINE64   = 64'(spd_pkg::LINE_BYTES);
    localparam logic [63:0] SPAN64   = 64'(spd_pkg::LOOKAHEAD * spd_pkg::LINE_BYTES);
    localparam logic [63:0] FRAME64  = ~(64'(spd_pkg::PAGE_BYTES) - 64'd1);
    localparam logic [63:0] ADDR_TOP = (64'd1 << spd_pkg::ADDR_W) - 64'd1;
    localparam int          REG_SEL_BIT = 3;

    logic [1:0]                  stream_conf [spd_pkg::STREAM_COUNT];
    logic [1:0]                  stream_dir  [spd_pkg::STREAM_COUNT];
    spd_pkg::t_addr              stream_last [spd_pkg::STREAM_COUNT];
    spd_pkg::t_addr              stream_head [spd_pkg::STREAM_COUNT];
    int                          stream_age  [spd_pkg::STREAM_COUNT];
    logic [spd_pkg::LIMIT_W-1:0] mem_limit;
    t_prefetch                   prefetch_due [$];
    int                          errors;
    int                          misses;
    int                          prefetches;
    int                          blocked;

    function automatic bit fill_ok(logic [63:0] from, logic [63:0] nxt);
        logic [63:0] lim;
        lim = 64'(mem_limit);
        if ((nxt & FRAME64) != (from & FRAME64)) return 1'b0;
        if (nxt < LINE64) return 1'b0;
        if (lim < LINE64 || nxt > lim - LINE64) return 1'b0;
        return 1'b1;
    endfunction

    // A steady stream takes a miss past its last miss and no more than a line past its head
    function automatic bit steady_hit(int idx, logic [63:0] miss);
        logic [63:0] last, head;
        last = 64'(stream_last[idx]);
        head = 64'(stream_head[idx]);
        if (stream_dir[idx] == spd_pkg::DIR_FORWARD) begin
            if (!(miss > last && miss - last >= LINE64)) return 1'b0;
            return miss <= head || miss - head <= LINE64;
        end
        if (stream_dir[idx] == spd_pkg::DIR_BACKWARD) begin
            if (!(last > miss && last - miss >= LINE64)) return 1'b0;
            return miss >= head || head - miss <= LINE64;
        end
        return 1'b0;
    endfunction

    task automatic touch(int idx);
        int mine;
        mine = stream_age[idx];
        for (int j = 0; j < spd_pkg::STREAM_COUNT; j++) begin
            if (stream_age[j] < mine) stream_age[j]++;
        end
        stream_age[idx] = 0;
    endtask

    task automatic predict_burst(input spd_pkg::t_addr miss_addr);
        logic [63:0]    miss, last, head, nxt;
        spd_pkg::t_addr burst [$];
        t_prefetch      entry;
        int             i;
        int             victim;
        bit             hit;
        bit             fwd;
        miss = 64'(miss_addr);
        hit  = 1'b0;
        for (i = 0; i < spd_pkg::STREAM_COUNT; i++) begin
            last = 64'(stream_last[i]);
            if (stream_conf[i] == spd_pkg::CONF_TRAINING) begin
                // guard against wrapping past either end of the address range
                if (last <= ADDR_TOP - LINE64 && miss == last + LINE64) begin
                    stream_dir[i] = spd_pkg::DIR_FORWARD;
                    hit = 1'b1;
                end else if (last >= LINE64 && miss == last - LINE64) begin
                    stream_dir[i] = spd_pkg::DIR_BACKWARD;
                    hit = 1'b1;
                end
                if (hit) begin
                    stream_conf[i] = spd_pkg::CONF_STEADY;
                    stream_head[i] = miss_addr;
                end
            end else if (stream_conf[i] == spd_pkg::CONF_STEADY) begin
                hit = steady_hit(i, miss);
            end
            if (hit) break;
        end

        if (!hit) begin
            // reallocate the oldest entry; the lowest index wins a tie
            victim = 0;
            for (int j = 1; j < spd_pkg::STREAM_COUNT; j++) begin
                if (stream_age[j] > stream_age[victim]) victim = j;
            end
            stream_last[victim] = miss_addr;
            stream_head[victim] = miss_addr;
            stream_dir[victim]  = spd_pkg::DIR_UNKNOWN;
            stream_conf[victim] = spd_pkg::CONF_TRAINING;
            touch(victim);
            return;
        end

        fwd = (stream_dir[i] == spd_pkg::DIR_FORWARD);
        stream_last[i] = miss_addr;
        for (int k = 0; k <= spd_pkg::LOOKAHEAD; k++) begin
            head = 64'(stream_head[i]);
            if (fwd) begin
                if (head >= miss && head - miss >= SPAN64) break;
                nxt = head + LINE64;
            end else begin
                if (miss >= head && miss - head >= SPAN64) break;
                nxt = head - LINE64;
            end
            // drop back to training and keep the last issued head
            if (!fill_ok(head, nxt)) begin
                stream_conf[i] = spd_pkg::CONF_TRAINING;
                stream_dir[i]  = spd_pkg::DIR_UNKNOWN;
                blocked++;
                break;
            end
            stream_head[i] = nxt[spd_pkg::ADDR_W-1:0];
            burst.push_back(nxt[spd_pkg::ADDR_W-1:0]);
        end
        foreach (burst[j]) begin
            entry.addr = burst[j];
            entry.last = (j == burst.size() - 1);
            prefetch_due.push_back(entry);
        end
        touch(i);
    endtask

    always @(posedge i_clk) begin : watch
        t_prefetch want;
        if (!i_rst_n) begin
            for (int j = 0; j < spd_pkg::STREAM_COUNT; j++) begin
                stream_conf[j] = spd_pkg::CONF_INVALID;
                stream_dir[j]  = spd_pkg::DIR_UNKNOWN;
                stream_last[j] = '0;
                stream_head[j] = '0;
                stream_age[j]  = spd_pkg::STREAM_COUNT - 1 - j;
            end
            mem_limit = spd_pkg::LIMIT_RESET;
            prefetch_due.delete();
        end else begin
            if (psel && penable && pwrite && pready
                    && paddr[REG_SEL_BIT] == spd_pkg::REG_MEMORY_LIMIT) begin
                mem_limit = pwdata[spd_pkg::LIMIT_W-1:0];
            end
            if (prefetch_valid && prefetch_ready) begin
                prefetches++;
                if (prefetch_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected prefetch request: expected none, got %h last %b",
                             $time, prefetch_address, burst_last);
                end else begin
                    want = prefetch_due.pop_front();
                    if (prefetch_address !== want.addr) begin
                        errors++;
                        $display("%0t: prefetch address: expected %h, got %h",
                                 $time, want.addr, prefetch_address);
                    end
                    if (burst_last !== want.last) begin
                        errors++;
                        $display("%0t: burst last flag at %h: expected %b, got %b",
                                 $time, want.addr, want.last, burst_last);
                    end
                end
            end
            if (miss_valid && miss_ready) begin
                misses++;
                predict_burst(miss_address);
            end
        end
        fail_count     <= errors;
        pending_count  <= prefetch_due.size();
        miss_count     <= misses;
        prefetch_count <= prefetches;
        blocked_count  <= blocked;
    end

endmodule

### tb/sv/stream_prefetch_detector_test.sv
// Stimulus and verdict for the stream prefetch detector testbench.
`timescale 1ns / 1ps

module stream_prefetch_detector_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LANES         = 3;
    localparam logic [spd_pkg::PADDR_W-1:0] LIMIT_PADDR =
        spd_pkg::PADDR_W'({spd_pkg::REG_MEMORY_LIMIT, 3'b000});

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    spd_pkg::t_addr               i_miss_address = '0;
    logic                         i_miss_valid = 1'b0;
    logic                         o_miss_ready;
    spd_pkg::t_addr               o_prefetch_address;
    logic                         o_burst_last;
    logic                         o_prefetch_valid;
    logic                         i_prefetch_ready = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [spd_pkg::PADDR_W-1:0]  paddr = '0;
    logic [spd_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [spd_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    int fail_count;
    int pending_count;
    int miss_count;
    int prefetch_count;
    int blocked_count;

    int                          cycle_count = 0;
    int                          ready_run = 0;
    int                          send_run = 0;
    logic [spd_pkg::LIMIT_W-1:0] cfg_limit = spd_pkg::LIMIT_RESET;
    spd_pkg::t_addr              lane_pos  [LANES];
    bit                          lane_down [LANES];
    int                          lane_left [LANES];
    spd_pkg::t_addr              opening_misses [21];

    stream_prefetch_detector DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_miss_address     (i_miss_address),
        .i_miss_valid       (i_miss_valid),
        .o_miss_ready       (o_miss_ready),
        .o_prefetch_address (o_prefetch_address),
        .o_burst_last       (o_burst_last),
        .o_prefetch_valid   (o_prefetch_valid),
        .i_prefetch_ready   (i_prefetch_ready),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    stream_prefetch_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .miss_valid       (i_miss_valid),
        .miss_ready       (o_miss_ready),
        .miss_address     (i_miss_address),
        .prefetch_valid   (o_prefetch_valid),
        .prefetch_ready   (i_prefetch_ready),
        .prefetch_address (o_prefetch_address),
        .burst_last       (o_burst_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .miss_count       (miss_count),
        .prefetch_count   (prefetch_count),
        .blocked_count    (blocked_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: alternate ready and stall runs, now and then a long stretch with no stall
    always @(posedge i_clk) begin
        if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else if (i_prefetch_ready) begin
            i_prefetch_ready <= 1'b0;
            ready_run <= $urandom_range(0, 11);
        end else begin
            i_prefetch_ready <= 1'b1;
            ready_run <= ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 9);
        end
    end

    // Stream start, mostly below the memory limit, often near a page edge or the limit
    function automatic spd_pkg::t_addr pick_start();
        logic [63:0] room, pick;
        int unsigned sel;
        room = 64'(cfg_limit);
        if (room < 64'(spd_pkg::LINE_BYTES)) room = 64'd1 << spd_pkg::ADDR_W;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            pick = {$urandom, $urandom} % room;
        end else if (sel < 70) begin
            pick = (({$urandom, $urandom} % room) & ~64'(spd_pkg::PAGE_BYTES - 1))
                   + 64'($urandom_range(0, 10)) * 64'(spd_pkg::LINE_BYTES)
                   - 64'(5 * spd_pkg::LINE_BYTES);
        end else if (sel < 85) begin
            pick = room - 64'($urandom_range(1, 12)) * 64'(spd_pkg::LINE_BYTES);
        end else begin
            pick = {$urandom, $urandom};
        end
        if ($urandom_range(0, 9) != 0) pick[spd_pkg::LINE_SHIFT-1:0] = '0;
        return pick[spd_pkg::ADDR_W-1:0];
    endfunction

    // Interleave a few unit-stride streams with scattered noise misses
    function automatic spd_pkg::t_addr next_miss();
        logic [63:0] noise;
        int lane;
        int stride;
        if ($urandom_range(0, 99) < 12) begin
            noise = {$urandom, $urandom};
            if ($urandom_range(0, 1) != 0) noise[spd_pkg::LINE_SHIFT-1:0] = '0;
            return noise[spd_pkg::ADDR_W-1:0];
        end
        lane = $urandom_range(0, LANES - 1);
        if (lane_left[lane] == 0) begin
            lane_pos[lane]  = pick_start();
            lane_down[lane] = ($urandom_range(0, 1) != 0);
            lane_left[lane] = $urandom_range(6, 24);
            return lane_pos[lane];
        end
        // mostly the next line, sometimes a skipped line or a repeated miss
        stride = $urandom_range(0, 19);
        stride = (stride == 0) ? 0 : (stride < 3) ? 2 : 1;
        lane_left[lane]--;
        if (lane_down[lane])
            lane_pos[lane] = lane_pos[lane] - spd_pkg::ADDR_W'(stride * spd_pkg::LINE_BYTES);
        else
            lane_pos[lane] = lane_pos[lane] + spd_pkg::ADDR_W'(stride * spd_pkg::LINE_BYTES);
        return lane_pos[lane];
    endfunction

    task automatic send_miss(input spd_pkg::t_addr addr);
        int gap;
        if (send_run == 0) begin
            send_run = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_miss_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        send_run--;
        i_miss_valid   <= 1'b1;
        i_miss_address <= addr;
        do @(posedge i_clk); while (!o_miss_ready);
    endtask

    // Hold off until every prefetch request is in, then let a miss with no burst finish
    task automatic drain_and_settle();
        i_miss_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [spd_pkg::LIMIT_W-1:0] limit, input int items);
        drain_and_settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_PADDR;
        pwdata  <= spd_pkg::PDATA_W'(limit);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_limit = limit;
        repeat (items) send_miss(next_miss());
    endtask

    initial begin
        opening_misses = '{
            48'h0000_0000_00C0, 48'h0000_0000_0080, 48'h0000_0000_0000,
            48'hFFFF_FFFF_FFC0, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_003F,
            48'hFFFF_FFFF_FF80, 48'h0000_0000_2000, 48'h0000_0000_2040,
            48'h0000_0000_2080, 48'h0000_0000_2100, 48'h0000_0000_2100,
            48'h0000_0000_1100, 48'h0000_0000_10C0, 48'h0000_0000_1080,
            48'h0000_0000_1040, 48'h0000_FFFF_FF40, 48'h0000_FFFF_FF80,
            48'h0000_FFFF_FFC0, 48'h5555_5555_5540, 48'hAAAA_AAAA_AA80
        };
        foreach (lane_left[j]) lane_left[j] = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // edges of the address range, page and one-line bounds, skips and repeats
        foreach (opening_misses[j]) send_miss(opening_misses[j]);
        repeat (40) send_miss(next_miss());

        run_phase(49'h1_0000_0000_0000, 55);
        run_phase(49'h0, 25);
        run_phase(49'h0_0000_0001_2345, 60);
        run_phase(spd_pkg::LIMIT_W'({$urandom_range(0, 16'hFFFF), $urandom}), 55);
        run_phase(spd_pkg::LIMIT_RESET, 55);
        drain_and_settle();

        $display("Covered %0d miss requests and %0d prefetch requests under six memory limits,",
                 miss_count, prefetch_count);
        $display("with %0d bursts cut short at a page edge, the first line or the memory limit.",
                 blocked_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/spd_pkg.sv
rtl/core/spd_front.sv
rtl/core/spd_cmd_queue.sv
rtl/core/spd_back.sv
rtl/core/stream_prefetch_detector.sv
tb/sv/stream_prefetch_checker.sv
tb/sv/stream_prefetch_detector_test.sv
